// File: hdl/uri_percent_decoder_defines.svh
// Assertion macros used by the checker file, upd_checker.sv.
`ifndef URI_PERCENT_DECODER_DEFINES_SVH
`define URI_PERCENT_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UPD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("upd assertion failed");

// Next-cycle implication, disabled during reset.
`define UPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("upd assertion failed");

`endif

// File: hdl/upd_pkg.sv
package upd_pkg;

  localparam int unsigned MaxResults = 3;
  localparam logic [7:0] PctChar = 8'h25;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_HEX1  = 2'd1,
    PH_HEX2  = 2'd2,
    PH_PCT   = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] cont_left;
    logic [7:0] first_hex;
    logic       dropping;
  } state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       error;
    logic       last;
  } res_t;

  typedef res_t [MaxResults-1:0] res_group_t;

endpackage

// File: hdl/upd_core.sv
module upd_core
  import upd_pkg::*;
(
  input  state_t     st,
  input  logic       keep_reserved,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output state_t     st_next,
  output logic [1:0] nres,
  output res_group_t res
);

  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [4:0] v;
    v = 5'h10;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      v = {1'b0, ch[3:0]};
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      v = {1'b0, ch[3:0] + 4'd9};
    end
    return v;
  endfunction

  function automatic logic is_reserved(input logic [7:0] c);
    logic r;
    case (c) inside
      8'h3b, 8'h2f, 8'h3f, 8'h3a, 8'h40, 8'h26, 8'h3d, 8'h2b, 8'h24, 8'h2c, 8'h23: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  logic [4:0] h1;
  logic [4:0] h2;
  logic [7:0] c;
  logic [1:0] cont;
  logic [1:0] left_dec;
  logic       fail;

  assign h1       = hex_value(st.first_hex);
  assign h2       = hex_value(in_byte);
  assign c        = {h1[3:0], h2[3:0]};
  assign left_dec = st.cont_left - 2'd1;

  always_comb begin
    if ((c & 8'hf8) == 8'hf0) begin
      cont = 2'd3;
    end else if ((c & 8'hf0) == 8'he0) begin
      cont = 2'd2;
    end else if ((c & 8'he0) == 8'hc0) begin
      cont = 2'd1;
    end else begin
      cont = 2'd0;
    end
  end

  always_comb begin
    st_next = st;
    nres    = 2'd0;
    res     = '0;
    fail    = 1'b0;
    if (st.dropping) begin
      if (in_last) begin
        st_next = '0;
      end
    end else begin
      case (st.phase)
        PH_HEX1: begin
          if (h2[4] || in_last) begin
            fail = 1'b1;
          end else begin
            st_next.first_hex = in_byte;
            st_next.phase     = PH_HEX2;
          end
        end
        PH_HEX2: begin
          if (h1[4] || h2[4]) begin
            fail = 1'b1;
          end else if (st.cont_left != 2'd0) begin
            if (in_last && left_dec != 2'd0) begin
              fail = 1'b1;
            end else begin
              st_next.cont_left = left_dec;
              st_next.phase     = (left_dec != 2'd0) ? PH_PCT : PH_PLAIN;
              res[0]            = '{data: c, error: 1'b0, last: in_last};
              nres              = 2'd1;
            end
          end else if (c[7]) begin
            if (cont == 2'd0 || in_last) begin
              fail = 1'b1;
            end else begin
              st_next.cont_left = cont;
              st_next.phase     = PH_PCT;
              res[0]            = '{data: c, error: 1'b0, last: 1'b0};
              nres              = 2'd1;
            end
          end else begin
            st_next.phase = PH_PLAIN;
            if (keep_reserved && is_reserved(c)) begin
              res[0] = '{data: PctChar, error: 1'b0, last: 1'b0};
              res[1] = '{data: st.first_hex, error: 1'b0, last: 1'b0};
              res[2] = '{data: in_byte, error: 1'b0, last: in_last};
              nres   = 2'd3;
            end else begin
              res[0] = '{data: c, error: 1'b0, last: in_last};
              nres   = 2'd1;
            end
          end
        end
        PH_PCT: begin
          if (in_byte != PctChar || in_last) begin
            fail = 1'b1;
          end else begin
            st_next.phase = PH_HEX1;
          end
        end
        default: begin
          if (in_byte == PctChar) begin
            if (in_last) begin
              fail = 1'b1;
            end else begin
              st_next.cont_left = 2'd0;
              st_next.phase     = PH_HEX1;
            end
          end else begin
            st_next.phase = PH_PLAIN;
            res[0]        = '{data: in_byte, error: 1'b0, last: in_last};
            nres          = 2'd1;
          end
        end
      endcase
      if (fail) begin
        st_next          = '0;
        st_next.dropping = !in_last;
        res              = '0;
        res[0]           = '{data: 8'h00, error: 1'b1, last: 1'b1};
        nres             = 2'd1;
      end
    end
  end

endmodule

// File: hdl/upd_out.sv
module upd_out
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [1:0] nres,
  input  res_group_t res,
  output logic       can_load,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tuser,
  output logic       m_tlast
);

  logic [1:0] count;
  logic [1:0] count_next;
  res_group_t buffer;
  logic       pop;

  assign m_tvalid = (count != 2'd0);
  assign pop      = m_tvalid && m_tready;
  assign can_load = (count == 2'd0) || (count == 2'd1 && m_tready);
  assign m_tdata  = buffer[0].data;
  assign m_tuser  = buffer[0].error;
  assign m_tlast  = buffer[0].last;

  always_comb begin
    count_next = count;
    if (load) begin
      count_next = nres;
    end else if (pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // advance the queue on a pop, overwrite it on a load
  always_ff @(posedge clk) begin
    if (load) begin
      buffer <= res;
    end else if (pop) begin
      buffer[0] <= buffer[1];
      buffer[1] <= buffer[2];
    end
  end

endmodule

// File: hdl/uri_percent_decoder.sv
// URI percent decoder: takes one encoded byte per cycle on the s_ stream and
// gives decoded bytes on the m_ stream. Each accepted byte yields zero, one or
// three requests; a byte is accepted every cycle unless the three-entry result
// queue holds more than one request, or holds one that the m_ side is not
// taking, so an escape of a reserved character in keep mode (three results)
// holds the input while the queue drains; all other bytes sustain one byte
// per cycle while m_tready stays high. Results appear on the m_ stream in the
// cycle after their byte is accepted. Errors come out as a single request
// with tuser set, tdata zero and tlast set; the rest of that string is dropped
// up to its tlast byte. keep_reserved sits at APB address 0 and resets to 1.
module uri_percent_decoder
  import upd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte[7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tuser,   // out_error
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t     st;
  state_t     st_next;
  logic       keep_reserved;
  logic [1:0] nres;
  res_group_t res;
  logic       can_load;
  logic       accept;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == 1'b0) ? {31'd0, keep_reserved} : 32'd0;
  assign s_tready = can_load;
  assign accept   = s_tvalid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_reserved <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      keep_reserved <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  upd_core u_core (
    .st            (st),
    .keep_reserved (keep_reserved),
    .in_byte       (s_tdata),
    .in_last       (s_tlast),
    .st_next       (st_next),
    .nres          (nres),
    .res           (res)
  );

  upd_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .nres     (nres),
    .res      (res),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: hdl/upd_checker.sv
`include "uri_percent_decoder_defines.svh"

module upd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  logic [9:0] m_word;

  assign m_word = {m_tlast, m_tuser, m_tdata};

  `UPD_ASSERT_NOW(a_error_shape, clk, rst, m_tvalid && m_tuser, m_tdata == 8'h00 && m_tlast)
  `UPD_ASSERT_NOW(a_ready_when_empty, clk, rst, !m_tvalid, s_tready)
  `UPD_ASSERT_NEXT(a_hold_stalled, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_word))

endmodule

bind uri_percent_decoder upd_checker u_upd_checker (.*);
